// File: sv/fspv_pkg.sv
// ----------------------------------------------------------------------------
// fspv_pkg: shared constants, types and tables
// Widths, register codes, queue item and state types, and the arctangent
// table for the five-step phase and visibility block.
// ----------------------------------------------------------------------------
package fspv_pkg;

  // Build-time sizing
  localparam int MAX_STEP     = 16;
  localparam int SAMPLE_BITS  = 12;
  localparam int CORDIC_ITERS = 16;

  // Tap line storage: a circular buffer holding at least 4*MAX_STEP+1 samples
  localparam int TAP_DEPTH = 4 * MAX_STEP + 1;
  localparam int TAP_AW    = $clog2(TAP_DEPTH);
  localparam int RAM_DEPTH = 2 ** TAP_AW;
  localparam int TAP_READS = 4;
  localparam int TAP_RD_W  = $clog2(TAP_READS);

  // Register fields
  localparam int STEP_W = 5;
  localparam int SINE_W = 16;
  localparam logic [SINE_W-1:0] SINE_MAX  = SINE_W'(32768);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2);
  localparam int SINE_FRAC = 14;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_STEP_SPACING = 1'b0;
  localparam logic [0:0] REG_SINE_FACTOR  = 1'b1;

  // Datapath widths
  localparam int COUNT_W = 16;
  localparam int MAG_W   = SAMPLE_BITS + 1;   // |N| and |D|
  localparam int NUM_W   = SAMPLE_BITS + 2;   // signed N
  localparam int DEN_W   = SAMPLE_BITS + 2;   // signed D
  localparam int PROD_W  = SINE_W + SAMPLE_BITS;

  // Square root unit
  localparam int SQRT_STEPS = MAG_W + 1;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int REM_W      = SQRT_STEPS + 3;
  localparam int SQ_CYCLES  = SQRT_STEPS + 2;
  localparam int SQ_CNT_W   = $clog2(SQ_CYCLES + 1);

  // CORDIC unit
  localparam int XY_W       = MAG_W + 12;
  localparam int Z_W        = 28;
  localparam int PRE_SHIFT  = 8;
  localparam int CD_CNT_W   = $clog2(CORDIC_ITERS + 1);
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IW    = $clog2(ATAN_ENTRIES);
  localparam logic signed [Z_W-1:0] PI_Q24 = Z_W'(52707179);
  localparam int PH_FRAC    = 12;

  // Result fields
  localparam int PHASE_W = 15;
  localparam int VIS_W   = 14;
  localparam logic [PHASE_W-1:0] PHASE_LIMIT = PHASE_W'(12868);
  localparam logic [VIS_W-1:0]   VIS_MAX     = VIS_W'(16383);

  // Two-entry queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [STEP_W-1:0] step_spacing;
    logic [SINE_W-1:0] sine_factor;
  } cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic [COUNT_W-1:0]      center;
    logic                    first;
    logic                    last;
  } item_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_READ,
    F_DRAIN,
    F_DIFF,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_FIN
  } back_state_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [ATAN_IW-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = Z_W'(13176795);
      5'd1:  v = Z_W'(7778716);
      5'd2:  v = Z_W'(4110060);
      5'd3:  v = Z_W'(2086331);
      5'd4:  v = Z_W'(1047214);
      5'd5:  v = Z_W'(524117);
      5'd6:  v = Z_W'(262123);
      5'd7:  v = Z_W'(131069);
      5'd8:  v = Z_W'(65536);
      5'd9:  v = Z_W'(32768);
      5'd10: v = Z_W'(16384);
      5'd11: v = Z_W'(8192);
      5'd12: v = Z_W'(4096);
      5'd13: v = Z_W'(2048);
      5'd14: v = Z_W'(1024);
      5'd15: v = Z_W'(512);
      5'd16: v = Z_W'(256);
      5'd17: v = Z_W'(128);
      5'd18: v = Z_W'(64);
      5'd19: v = Z_W'(32);
      5'd20: v = Z_W'(16);
      5'd21: v = Z_W'(8);
      5'd22: v = Z_W'(4);
      5'd23: v = Z_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/fspv_if.sv
// ----------------------------------------------------------------------------
// fspv_if: stream channels
// Valid/ready channels for intensity samples and for phase results.
// ----------------------------------------------------------------------------
interface fspv_in_if;
  logic                             valid;
  logic                             ready;
  logic [fspv_pkg::SAMPLE_BITS-1:0] sample;
  logic                             last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface fspv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fspv_pkg::PHASE_W-1:0] phase;
  logic [fspv_pkg::VIS_W-1:0]          visibility;
  logic [fspv_pkg::COUNT_W-1:0]        center_index;
  logic [fspv_pkg::COUNT_W-1:0]        peak_index;
  logic [fspv_pkg::VIS_W-1:0]          peak_visibility;
  logic                                is_last;

  modport source (output valid, output phase, output visibility, output center_index,
                  output peak_index, output peak_visibility, output is_last,
                  input ready);
  modport sink   (input valid, input phase, input visibility, input center_index,
                  input peak_index, input peak_visibility, input is_last,
                  output ready);
endinterface

// File: sv/fspv_ram.sv
// ----------------------------------------------------------------------------
// fspv_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fspv_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fspv_front.sv
// ----------------------------------------------------------------------------
// fspv_front: sample intake and tap arithmetic
// Writes samples into the circular tap buffer, decides whether a result is
// due, reads the four older taps and forms N and D for the back end.
// ----------------------------------------------------------------------------
module fspv_front (
  input  logic            clk,
  input  logic            rst_n,
  fspv_in_if.sink         in_ch,
  input  fspv_pkg::cfg_t  cfg,
  output logic            q_push,
  output fspv_pkg::item_t q_item,
  input  logic            q_full
);

  fspv_pkg::front_state_t state_r, state_nxt;

  logic [fspv_pkg::COUNT_W-1:0]      count_r;
  logic [fspv_pkg::TAP_AW-1:0]       wp_r;
  logic [fspv_pkg::TAP_AW-1:0]       raddr_r;
  logic [fspv_pkg::TAP_RD_W-1:0]     rd_cnt_r;
  logic                              cap_en_r;
  logic [fspv_pkg::TAP_RD_W-1:0]     cap_idx_r;
  logic [fspv_pkg::SAMPLE_BITS-1:0]  taps_r [fspv_pkg::TAP_READS];
  logic [fspv_pkg::SAMPLE_BITS-1:0]  far_r;
  logic [fspv_pkg::STEP_W-1:0]       step_r;
  logic [fspv_pkg::SINE_W-1:0]       k_r;
  logic                              last_r;
  logic                              first_r;
  logic [fspv_pkg::COUNT_W-1:0]      center_r;
  logic [fspv_pkg::SAMPLE_BITS-1:0]  ad_r;
  logic                              dneg_r;
  logic signed [fspv_pkg::DEN_W-1:0] den_r;
  logic [fspv_pkg::PROD_W-1:0]       prod_r;

  logic [fspv_pkg::STEP_W-1:0]       s_eff;
  logic [fspv_pkg::SINE_W-1:0]       k_eff;
  logic [fspv_pkg::COUNT_W-1:0]      thr_c;
  logic [fspv_pkg::COUNT_W-1:0]      center_c;
  logic                              accept;
  logic                              produce;
  logic                              rd_en;
  logic [fspv_pkg::SAMPLE_BITS-1:0]  rd_data;
  logic signed [fspv_pkg::SAMPLE_BITS:0] d_c;
  logic [fspv_pkg::SAMPLE_BITS:0]    ad_c;
  logic signed [fspv_pkg::DEN_W-1:0] den_c;
  logic [fspv_pkg::PROD_W:0]         round_c;
  logic [fspv_pkg::MAG_W-1:0]        nm_c;

  // Clamp configuration to its legal range
  always_comb begin
    if (cfg.step_spacing == '0) begin
      s_eff = fspv_pkg::STEP_W'(1);
    end else if (cfg.step_spacing > fspv_pkg::STEP_W'(fspv_pkg::MAX_STEP)) begin
      s_eff = fspv_pkg::STEP_W'(fspv_pkg::MAX_STEP);
    end else begin
      s_eff = cfg.step_spacing;
    end
    k_eff = (cfg.sine_factor > fspv_pkg::SINE_MAX) ? fspv_pkg::SINE_MAX : cfg.sine_factor;
  end

  // Warm-up check and center position
  assign thr_c    = fspv_pkg::COUNT_W'({s_eff, 2'b00});
  assign center_c = count_r - fspv_pkg::COUNT_W'({s_eff, 1'b0});
  assign accept   = in_ch.valid && in_ch.ready;
  assign produce  = (count_r >= thr_c);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fspv_pkg::F_IDLE: begin
        if (accept && produce) begin
          state_nxt = fspv_pkg::F_READ;
        end
      end
      fspv_pkg::F_READ: begin
        if (rd_cnt_r == fspv_pkg::TAP_RD_W'(fspv_pkg::TAP_READS - 1)) begin
          state_nxt = fspv_pkg::F_DRAIN;
        end
      end
      fspv_pkg::F_DRAIN: state_nxt = fspv_pkg::F_DIFF;
      fspv_pkg::F_DIFF:  state_nxt = fspv_pkg::F_MUL;
      fspv_pkg::F_MUL:   state_nxt = fspv_pkg::F_PUSH;
      fspv_pkg::F_PUSH: begin
        if (!q_full) begin
          state_nxt = fspv_pkg::F_IDLE;
        end
      end
      default: state_nxt = fspv_pkg::F_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == fspv_pkg::F_IDLE);
  assign rd_en       = (state_r == fspv_pkg::F_READ);
  assign q_push      = (state_r == fspv_pkg::F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fspv_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tap buffer: newest sample at wp, older taps at wp - j*s
  fspv_ram #(
    .WIDTH (fspv_pkg::SAMPLE_BITS),
    .DEPTH (fspv_pkg::RAM_DEPTH)
  ) u_tap_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (in_ch.sample),
    .re    (rd_en),
    .raddr (raddr_r),
    .rdata (rd_data)
  );

  // Sample count and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wp_r     <= '0;
      cap_en_r <= 1'b0;
    end else begin
      cap_en_r <= rd_en;
      if (accept) begin
        wp_r <= wp_r + 1'b1;
        if (in_ch.last_sample) begin
          count_r <= '0;
        end else if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  // Tap arithmetic
  assign d_c   = $signed({1'b0, taps_r[2]}) - $signed({1'b0, taps_r[0]});
  assign ad_c  = d_c[fspv_pkg::SAMPLE_BITS] ? -d_c : d_c;
  assign den_c = $signed(fspv_pkg::DEN_W'({taps_r[1], 1'b0})
                         - fspv_pkg::DEN_W'(far_r)
                         - fspv_pkg::DEN_W'(taps_r[3]));

  // Per-request capture and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      far_r    <= in_ch.sample;
      step_r   <= s_eff;
      k_r      <= k_eff;
      last_r   <= in_ch.last_sample;
      first_r  <= (count_r == thr_c);
      center_r <= center_c;
      raddr_r  <= wp_r - fspv_pkg::TAP_AW'(s_eff);
      rd_cnt_r <= '0;
    end else if (rd_en) begin
      raddr_r  <= raddr_r - fspv_pkg::TAP_AW'(step_r);
      rd_cnt_r <= rd_cnt_r + 1'b1;
    end
    cap_idx_r <= rd_cnt_r;
    if (cap_en_r) begin
      taps_r[cap_idx_r] <= rd_data;
    end
    if (state_r == fspv_pkg::F_DIFF) begin
      ad_r   <= ad_c[fspv_pkg::SAMPLE_BITS-1:0];
      dneg_r <= d_c[fspv_pkg::SAMPLE_BITS];
      den_r  <= den_c;
    end
    if (state_r == fspv_pkg::F_MUL) begin
      prod_r <= k_r * ad_r;
    end
  end

  // k*|d| rounded half away from zero, sign restored
  assign round_c = (fspv_pkg::PROD_W + 1)'(prod_r)
                 + (fspv_pkg::PROD_W + 1)'(1 << (fspv_pkg::SINE_FRAC - 1));
  assign nm_c    = round_c[fspv_pkg::SINE_FRAC +: fspv_pkg::MAG_W];

  always_comb begin
    q_item.num    = dneg_r ? -$signed(fspv_pkg::NUM_W'(nm_c))
                           :  $signed(fspv_pkg::NUM_W'(nm_c));
    q_item.den    = den_r;
    q_item.center = center_r;
    q_item.first  = first_r;
    q_item.last   = last_r;
  end

`ifndef SYNTHESIS
  // A request that owes a result blocks intake until its taps are read
  a_busy_after_produce: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && produce) |=> !in_ch.ready)
    else $error("front accepted while tap reads pending");
`endif

endmodule

// File: sv/fspv_queue.sv
// ----------------------------------------------------------------------------
// fspv_queue: front-to-back queue
// Short register queue carrying N, D and bookkeeping to the back end.
// ----------------------------------------------------------------------------
module fspv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fspv_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output fspv_pkg::item_t head,
  output logic            empty
);

  fspv_pkg::item_t                mem_r [fspv_pkg::QUEUE_DEPTH];
  logic [fspv_pkg::QUEUE_AW-1:0]  wptr_r;
  logic [fspv_pkg::QUEUE_AW-1:0]  rptr_r;
  logic [fspv_pkg::QUEUE_CW-1:0]  fill_r;

  assign full  = (fill_r == fspv_pkg::QUEUE_CW'(fspv_pkg::QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = mem_r[rptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == fspv_pkg::QUEUE_AW'(fspv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == fspv_pkg::QUEUE_AW'(fspv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");
`endif

endmodule

// File: sv/fspv_back.sv
// ----------------------------------------------------------------------------
// fspv_back: phase and visibility engine
// CORDIC vectoring for atan2(N, D) in parallel with a digit-serial square
// root of N^2 + D^2, peak tracking and the result register.
// ----------------------------------------------------------------------------
module fspv_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fspv_pkg::item_t q_head,
  output logic            q_pop,
  fspv_out_if.source      out_ch
);

  fspv_pkg::back_state_t state_r, state_nxt;

  logic signed [fspv_pkg::XY_W-1:0]  x_r;
  logic signed [fspv_pkg::XY_W-1:0]  y_r;
  logic signed [fspv_pkg::Z_W-1:0]   z_r;
  logic                              zero_r;
  logic signed [fspv_pkg::DEN_W-1:0] den_r;
  logic [fspv_pkg::COUNT_W-1:0]      center_r;
  logic                              first_r;
  logic                              last_r;
  logic [fspv_pkg::CD_CNT_W-1:0]     cd_cnt_r;
  logic [fspv_pkg::SQ_CNT_W-1:0]     sq_cnt_r;
  logic [2*fspv_pkg::MAG_W-1:0]      nsq_r;
  logic [2*fspv_pkg::MAG_W-1:0]      dsq_r;
  logic [fspv_pkg::RAD_W-1:0]        rad_r;
  logic [fspv_pkg::SQRT_STEPS-1:0]   root_r;
  logic [fspv_pkg::REM_W-1:0]        rem_r;

  logic                              out_valid_r;
  logic signed [fspv_pkg::PHASE_W-1:0] phase_r;
  logic [fspv_pkg::VIS_W-1:0]        vis_r;
  logic [fspv_pkg::COUNT_W-1:0]      center_out_r;
  logic [fspv_pkg::COUNT_W-1:0]      best_idx_r;
  logic [fspv_pkg::VIS_W-1:0]        best_vis_r;
  logic                              is_last_r;

  logic                              cd_done;
  logic                              sq_done;
  logic                              load;
  logic                              head_dneg;
  logic [fspv_pkg::MAG_W-1:0]        head_nmag;
  logic [fspv_pkg::MAG_W-1:0]        dmag_c;
  logic signed [fspv_pkg::XY_W-1:0]  x_init;
  logic signed [fspv_pkg::XY_W-1:0]  y_init;
  logic signed [fspv_pkg::Z_W-1:0]   z_init;
  logic signed [fspv_pkg::XY_W-1:0]  x_sh;
  logic signed [fspv_pkg::XY_W-1:0]  y_sh;
  logic signed [fspv_pkg::Z_W-1:0]   atan_c;
  logic [fspv_pkg::REM_W-1:0]        cand_c;
  logic [fspv_pkg::REM_W-1:0]        trial_c;
  logic [fspv_pkg::Z_W-1:0]          z_abs;
  logic [fspv_pkg::Z_W:0]            z_rnd;
  logic [fspv_pkg::Z_W-fspv_pkg::PH_FRAC:0] ph_q;
  logic [fspv_pkg::PHASE_W-1:0]      ph_mag;
  logic signed [fspv_pkg::PHASE_W-1:0] phase_c;
  logic [fspv_pkg::SQRT_STEPS:0]     vis_rnd;
  logic [fspv_pkg::VIS_W-1:0]        vis_c;
  logic                              new_best;

  assign cd_done = (cd_cnt_r == fspv_pkg::CD_CNT_W'(fspv_pkg::CORDIC_ITERS));
  assign sq_done = (sq_cnt_r == fspv_pkg::SQ_CNT_W'(fspv_pkg::SQ_CYCLES));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      fspv_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = fspv_pkg::B_RUN;
        end
      end
      fspv_pkg::B_RUN: begin
        if (cd_done && sq_done) begin
          state_nxt = fspv_pkg::B_FIN;
        end
      end
      fspv_pkg::B_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          state_nxt = fspv_pkg::B_IDLE;
        end
      end
      default: state_nxt = fspv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fspv_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Starting vector: left half-plane is folded over with a +/-pi offset
  assign head_dneg = q_head.den[fspv_pkg::DEN_W-1];
  assign head_nmag = q_head.num[fspv_pkg::NUM_W-1]
                   ? fspv_pkg::MAG_W'(-q_head.num) : fspv_pkg::MAG_W'(q_head.num);
  assign dmag_c    = den_r[fspv_pkg::DEN_W-1]
                   ? fspv_pkg::MAG_W'(-den_r) : fspv_pkg::MAG_W'(den_r);

  always_comb begin
    x_init = fspv_pkg::XY_W'(q_head.den) <<< fspv_pkg::PRE_SHIFT;
    y_init = fspv_pkg::XY_W'(q_head.num) <<< fspv_pkg::PRE_SHIFT;
    z_init = '0;
    if (head_dneg) begin
      x_init = -x_init;
      y_init = -y_init;
      z_init = q_head.num[fspv_pkg::NUM_W-1] ? -fspv_pkg::PI_Q24 : fspv_pkg::PI_Q24;
    end
  end

  // One CORDIC micro-rotation per cycle
  assign x_sh   = x_r >>> cd_cnt_r;
  assign y_sh   = y_r >>> cd_cnt_r;
  assign atan_c = fspv_pkg::atan_q24(fspv_pkg::ATAN_IW'(cd_cnt_r));

  // One root bit per cycle
  assign cand_c  = {rem_r[fspv_pkg::REM_W-3:0], rad_r[fspv_pkg::RAD_W-1 -: 2]};
  assign trial_c = fspv_pkg::REM_W'({root_r, 2'b01});

  // Iteration counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_cnt_r <= '0;
      sq_cnt_r <= '0;
    end else if (q_pop) begin
      cd_cnt_r <= '0;
      sq_cnt_r <= '0;
    end else if (state_r == fspv_pkg::B_RUN) begin
      if (!cd_done) begin
        cd_cnt_r <= cd_cnt_r + 1'b1;
      end
      if (!sq_done) begin
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
    end
  end

  // Vector, angle and root datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r      <= x_init;
      y_r      <= y_init;
      z_r      <= z_init;
      zero_r   <= (q_head.num == '0) && (q_head.den == '0);
      den_r    <= q_head.den;
      center_r <= q_head.center;
      first_r  <= q_head.first;
      last_r   <= q_head.last;
      nsq_r    <= head_nmag * head_nmag;
    end else if (state_r == fspv_pkg::B_RUN) begin
      if (!cd_done) begin
        if (!y_r[fspv_pkg::XY_W-1]) begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_c;
        end else begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_c;
        end
      end
      if (sq_cnt_r == '0) begin
        dsq_r <= dmag_c * dmag_c;
      end else if (sq_cnt_r == fspv_pkg::SQ_CNT_W'(1)) begin
        rad_r  <= fspv_pkg::RAD_W'(nsq_r) + fspv_pkg::RAD_W'(dsq_r);
        root_r <= '0;
        rem_r  <= '0;
      end else if (!sq_done) begin
        rad_r <= rad_r << 2;
        if (cand_c >= trial_c) begin
          rem_r  <= cand_c - trial_c;
          root_r <= {root_r[fspv_pkg::SQRT_STEPS-2:0], 1'b1};
        end else begin
          rem_r  <= cand_c;
          root_r <= {root_r[fspv_pkg::SQRT_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // Phase: round angle to Q3.12, clamp to +/-pi
  always_comb begin
    z_abs  = z_r[fspv_pkg::Z_W-1] ? fspv_pkg::Z_W'(-z_r) : fspv_pkg::Z_W'(z_r);
    z_rnd  = (fspv_pkg::Z_W + 1)'(z_abs) + (fspv_pkg::Z_W + 1)'(1 << (fspv_pkg::PH_FRAC - 1));
    ph_q   = z_rnd[fspv_pkg::Z_W:fspv_pkg::PH_FRAC];
    ph_mag = (ph_q > (fspv_pkg::Z_W - fspv_pkg::PH_FRAC + 1)'(fspv_pkg::PHASE_LIMIT))
           ? fspv_pkg::PHASE_LIMIT : fspv_pkg::PHASE_W'(ph_q);
    if (zero_r) begin
      phase_c = '0;
    end else if (z_r[fspv_pkg::Z_W-1]) begin
      phase_c = -$signed(ph_mag);
    end else begin
      phase_c = $signed(ph_mag);
    end
  end

  // Visibility: round root to nearest, saturate
  assign vis_rnd  = (fspv_pkg::SQRT_STEPS + 1)'(root_r)
                  + (fspv_pkg::SQRT_STEPS + 1)'(rem_r > fspv_pkg::REM_W'(root_r));
  assign vis_c    = (vis_rnd > (fspv_pkg::SQRT_STEPS + 1)'(fspv_pkg::VIS_MAX))
                  ? fspv_pkg::VIS_MAX : fspv_pkg::VIS_W'(vis_rnd);
  assign new_best = first_r || (vis_c > best_vis_r);

  // Peak tracker and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      best_vis_r  <= '0;
      best_idx_r  <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (new_best) begin
          best_vis_r <= vis_c;
          best_idx_r <= center_r;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      phase_r      <= phase_c;
      vis_r        <= vis_c;
      center_out_r <= center_r;
      is_last_r    <= last_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.phase           = phase_r;
  assign out_ch.visibility      = vis_r;
  assign out_ch.center_index    = center_out_r;
  assign out_ch.peak_index      = best_idx_r;
  assign out_ch.peak_visibility = best_vis_r;
  assign out_ch.is_last         = is_last_r;

`ifndef SYNTHESIS
  a_peak_covers_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (best_vis_r >= vis_r))
    else $error("peak visibility below current result");

  a_fin_after_both_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fspv_pkg::B_FIN) |-> (cd_done && sq_done))
    else $error("result formed before CORDIC and root finished");
`endif

endmodule

// File: sv/five_step_phase_visibility_top.sv
// ----------------------------------------------------------------------------
// five_step_phase_visibility_top: five-step phase and visibility extractor
// Takes one pixel's intensity samples through a focus scan, returns wrapped
// phase, fringe visibility and the running visibility peak.
//
//   channel  | kind          | payload
//   ---------+---------------+--------------------------------------------
//   in_ch    | valid/ready   | sample[11:0], last_sample
//   out_ch   | valid/ready   | phase[14:0], visibility[13:0], center_index,
//            |               | peak_index, peak_visibility, is_last
//   cfg_*    | APB write/read| 0x0 step_spacing[4:0], 0x4 sine_factor[15:0]
//
// A sample that yields no result is taken while the front is idle. A sample
// that yields a result holds intake through four tap RAM reads, difference,
// multiply and the queue push; the back end runs 16 CORDIC iterations per
// result, the square root alongside, before it pops the next queue entry.
// Reset needs no clearing pass: the sample count guards every tap read.
// A waiting result sits in the output register; the two-entry queue lets the
// front keep taking samples while the back end or the sink stalls.
// ----------------------------------------------------------------------------
module five_step_phase_visibility_top (
  input  logic                          clk,
  input  logic                          rst_n,
  fspv_in_if.sink                       in_ch,
  fspv_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fspv_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fspv_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [fspv_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [fspv_pkg::STEP_W-1:0] step_r;
  logic [fspv_pkg::SINE_W-1:0] sine_r;
  fspv_pkg::cfg_t              cfg;
  logic                        cfg_wr;

  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  fspv_pkg::item_t             q_push_item;
  fspv_pkg::item_t             q_head;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fspv_pkg::STEP_RESET;
      sine_r <= fspv_pkg::SINE_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        fspv_pkg::REG_STEP_SPACING: step_r <= cfg_pwdata[fspv_pkg::STEP_W-1:0];
        fspv_pkg::REG_SINE_FACTOR:  sine_r <= cfg_pwdata[fspv_pkg::SINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      fspv_pkg::REG_STEP_SPACING: cfg_prdata = fspv_pkg::CFG_DW'(step_r);
      fspv_pkg::REG_SINE_FACTOR:  cfg_prdata = fspv_pkg::CFG_DW'(sine_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  assign cfg.step_spacing = step_r;
  assign cfg.sine_factor  = sine_r;

  fspv_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_push (q_push),
    .q_item (q_push_item),
    .q_full (q_full)
  );

  fspv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  fspv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
